FILE: hdl/ci_pkg.sv
`timescale 1ns / 1ps
// Shared constants, register codes and word types of the circle inversion block.
package ci_pkg;

    localparam int ADDR_W   = 5;
    localparam int QDEPTH   = 4;
    localparam int QP_W     = $clog2(QDEPTH);
    localparam int NUM_W    = 96;
    localparam int DEN_W    = 66;
    localparam int QUO_W    = 35;
    localparam int DIV_LAT  = QUO_W + 1;
    localparam int SQ_STEPS = 35;

    localparam logic [30:0] MAX31      = 31'h7FFF_FFFF;
    localparam logic [34:0] QCLAMP     = 35'h4_0000_0000;
    localparam logic [30:0] RADIUS_RST = 31'd524288;
    localparam logic [30:0] SPAN_RST   = 31'd65536000;

    typedef enum logic [2:0] {
        REG_CX     = 3'd0,
        REG_CY     = 3'd1,
        REG_RADIUS = 3'd2,
        REG_SPAN   = 3'd3,
        REG_TOL    = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [31:0] cx;
        logic [31:0] cy;
        logic [30:0] radius;
        logic [30:0] span;
        logic [15:0] tol;
    } cfg_t;

    // Classified word handed from the front part to the back part.
    typedef struct packed {
        logic        is_line;
        logic        xneg;
        logic        yneg;
        logic [32:0] adx;
        logic [32:0] ady;
        logic [34:0] dd;
        logic [30:0] r;
        logic [65:0] d2;
    } qword_t;

endpackage

FILE: hdl/ci_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for input circles and result images.
interface ci_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] circle_x;
    logic signed [31:0] circle_y;
    logic        [30:0] circle_r;

    modport source (output valid, output circle_x, output circle_y, output circle_r,
                    input ready);
    modport sink (input valid, input circle_x, input circle_y, input circle_r,
                  output ready);
endinterface

interface ci_out_if;
    logic               valid;
    logic               ready;
    logic               is_line;
    logic               overflow;
    logic signed [31:0] image_x;
    logic signed [31:0] image_y;
    logic        [30:0] image_r;
    logic signed [31:0] seg_start_x;
    logic signed [31:0] seg_start_y;
    logic signed [31:0] seg_end_x;
    logic signed [31:0] seg_end_y;

    modport source (output valid, output is_line, output overflow, output image_x,
                    output image_y, output image_r, output seg_start_x,
                    output seg_start_y, output seg_end_x, output seg_end_y,
                    input ready);
    modport sink (input valid, input is_line, input overflow, input image_x,
                  input image_y, input image_r, input seg_start_x,
                  input seg_start_y, input seg_end_x, input seg_end_y,
                  output ready);
endinterface

FILE: hdl/ci_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider: one quotient bit per stage, with range check.
module ci_div import ci_pkg::*; (
    input  logic             clk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [QUO_W-1:0] quo,
    output logic             ovf
);

    typedef struct packed {
        logic [DEN_W-1:0] rem;
        logic [QUO_W-1:0] low;
        logic [DEN_W-1:0] d;
        logic [QUO_W-1:0] q;
        logic             ovf;
    } dstage_t;

    dstage_t st_reg  [QUO_W+1];
    dstage_t st_next [QUO_W+1];

    function automatic dstage_t div_step(input dstage_t cur);
        logic [DEN_W:0] sh;
        logic           take;
        dstage_t        nxt;
        nxt  = cur;
        sh   = {cur.rem, cur.low[QUO_W-1]};
        take = sh >= {1'b0, cur.d};
        nxt.rem = take ? DEN_W'(sh - {1'b0, cur.d}) : DEN_W'(sh);
        nxt.low = cur.low << 1;
        nxt.q   = {cur.q[QUO_W-2:0], take};
        return nxt;
    endfunction

    always_comb
    begin
        // A quotient that needs more than QUO_W bits is flagged up front.
        st_next[0].rem = DEN_W'(num[NUM_W-1:QUO_W]);
        st_next[0].low = num[QUO_W-1:0];
        st_next[0].d   = den;
        st_next[0].q   = '0;
        st_next[0].ovf = (den == '0) || (DEN_W'(num[NUM_W-1:QUO_W]) >= den);
        for (int i = 1; i <= QUO_W; i++)
        begin
            st_next[i] = div_step(st_reg[i-1]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i <= QUO_W; i++)
            begin
                st_reg[i] <= st_next[i];
            end
        end
    end

    assign quo = st_reg[QUO_W].q;
    assign ovf = st_reg[QUO_W].ovf;

endmodule

FILE: hdl/ci_front.sv
`timescale 1ns / 1ps
// Front part: offsets, squared distance, pipelined square root and line test.
module ci_front import ci_pkg::*; (
    input  logic   clk,
    input  logic   rst_n,
    input  cfg_t   cfg,
    ci_in_if.sink  circle,
    output logic   push,
    output qword_t push_word,
    input  logic   full
);

    typedef struct packed {
        logic [32:0] dx;
        logic [32:0] dy;
        logic [30:0] r;
    } s0_t;

    typedef struct packed {
        logic [32:0] adx;
        logic [32:0] ady;
        logic        xneg;
        logic        yneg;
        logic [30:0] r;
    } s1_t;

    typedef struct packed {
        s1_t         p;
        logic [65:0] sqx;
        logic [65:0] sqy;
    } s2_t;

    typedef struct packed {
        s1_t         p;
        logic [65:0] d2;
        logic [65:0] rem;
        logic [34:0] root;
    } sq_t;

    logic   en;
    s0_t    s0_reg, s0_next;
    s1_t    s1_reg, s1_next;
    s2_t    s2_reg, s2_next;
    sq_t    sq_reg  [SQ_STEPS+1];
    sq_t    sq_next [SQ_STEPS+1];
    qword_t cls_reg, cls_next;
    logic   v0_reg, v1_reg, v2_reg, vc_reg;
    logic   sqv_reg [SQ_STEPS+1];

    function automatic sq_t sq_step(input sq_t cur, input int b);
        logic [69:0] trial;
        logic [69:0] rem_w;
        sq_t         nxt;
        nxt   = cur;
        // Root bits at and below b are still zero, so the square grows by this trial.
        trial = (70'(cur.root) << (b + 1)) | (70'(1) << (2 * b));
        rem_w = 70'(cur.rem);
        if (rem_w >= trial)
        begin
            nxt.rem  = 66'(rem_w - trial);
            nxt.root = cur.root | (35'(1) << b);
        end
        return nxt;
    endfunction

    assign en           = !(vc_reg && full);
    assign circle.ready = en;
    assign push         = vc_reg && !full;
    assign push_word    = cls_reg;

    always_comb
    begin
        logic [34:0] dd;
        logic [34:0] rr;
        logic [34:0] diff;
        s0_next.dx = {circle.circle_x[31], circle.circle_x} - {cfg.cx[31], cfg.cx};
        s0_next.dy = {circle.circle_y[31], circle.circle_y} - {cfg.cy[31], cfg.cy};
        s0_next.r  = circle.circle_r;

        s1_next.xneg = s0_reg.dx[32];
        s1_next.yneg = s0_reg.dy[32];
        s1_next.adx  = s0_reg.dx[32] ? 33'(0) - s0_reg.dx : s0_reg.dx;
        s1_next.ady  = s0_reg.dy[32] ? 33'(0) - s0_reg.dy : s0_reg.dy;
        s1_next.r    = s0_reg.r;

        s2_next.p   = s1_reg;
        s2_next.sqx = 66'(s1_reg.adx) * 66'(s1_reg.adx);
        s2_next.sqy = 66'(s1_reg.ady) * 66'(s1_reg.ady);

        sq_next[0].p    = s2_reg.p;
        sq_next[0].d2   = s2_reg.sqx + s2_reg.sqy;
        sq_next[0].rem  = s2_reg.sqx + s2_reg.sqy;
        sq_next[0].root = '0;
        for (int i = 1; i <= SQ_STEPS; i++)
        begin
            sq_next[i] = sq_step(sq_reg[i-1], SQ_STEPS - i);
        end

        dd   = sq_reg[SQ_STEPS].root;
        rr   = 35'(sq_reg[SQ_STEPS].p.r);
        diff = (dd > rr) ? dd - rr : rr - dd;
        cls_next.is_line = diff <= 35'(cfg.tol);
        cls_next.xneg    = sq_reg[SQ_STEPS].p.xneg;
        cls_next.yneg    = sq_reg[SQ_STEPS].p.yneg;
        cls_next.adx     = sq_reg[SQ_STEPS].p.adx;
        cls_next.ady     = sq_reg[SQ_STEPS].p.ady;
        cls_next.dd      = dd;
        cls_next.r       = sq_reg[SQ_STEPS].p.r;
        cls_next.d2      = sq_reg[SQ_STEPS].d2;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_reg  <= s0_next;
            s1_reg  <= s1_next;
            s2_reg  <= s2_next;
            for (int i = 0; i <= SQ_STEPS; i++)
            begin
                sq_reg[i] <= sq_next[i];
            end
            cls_reg <= cls_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            vc_reg <= 1'b0;
            for (int i = 0; i <= SQ_STEPS; i++)
            begin
                sqv_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            v0_reg     <= circle.valid;
            v1_reg     <= v0_reg;
            v2_reg     <= v1_reg;
            sqv_reg[0] <= v2_reg;
            for (int i = 1; i <= SQ_STEPS; i++)
            begin
                sqv_reg[i] <= sqv_reg[i-1];
            end
            vc_reg     <= sqv_reg[SQ_STEPS];
        end
    end

endmodule

FILE: hdl/ci_queue.sv
`timescale 1ns / 1ps
// Short queue of classified words between the front and back parts.
module ci_queue import ci_pkg::*; (
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  qword_t push_word,
    output logic   full,
    input  logic   pop,
    output qword_t pop_word,
    output logic   empty
);

    qword_t          data_reg [QDEPTH];
    logic [QP_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QP_W:0]   count_reg;

    assign full     = count_reg == (QP_W+1)'(QDEPTH);
    assign empty    = count_reg == '0;
    assign pop_word = data_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg[wr_ptr_reg] <= push_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

FILE: hdl/ci_back.sv
`timescale 1ns / 1ps
// Back part: inversion quotients, line offsets, saturation and output register.
module ci_back import ci_pkg::*; (
    input  logic   clk,
    input  logic   rst_n,
    input  cfg_t   cfg,
    output logic   pop,
    input  qword_t pop_word,
    input  logic   empty,
    ci_out_if.source image
);

    typedef struct packed {
        qword_t      w;
        logic [61:0] r2;
        logic [63:0] pxl;
        logic [63:0] pxh;
        logic [63:0] pyl;
        logic [63:0] pyh;
        logic [61:0] prl;
        logic [61:0] prh;
    } b1_t;

    typedef struct packed {
        logic             line;
        logic             xneg;
        logic             yneg;
        logic             dneg;
        logic [32:0]      adx;
        logic [32:0]      ady;
        logic [34:0]      dd;
        logic [30:0]      r;
        logic [NUM_W-1:0] nx;
        logic [NUM_W-1:0] ny;
        logic [NUM_W-1:0] nr;
        logic [DEN_W-1:0] den;
    } b2_t;

    typedef struct packed {
        logic        line;
        logic        xneg;
        logic        yneg;
        logic        dneg;
        logic [32:0] adx;
        logic [32:0] ady;
        logic [34:0] dd;
    } side1_t;

    typedef struct packed {
        logic        line;
        logic        xneg;
        logic        yneg;
        logic        ov;
        logic [34:0] dd;
        logic [63:0] pox;
        logic [63:0] poy;
        logic [63:0] ptx;
        logic [63:0] pty;
        logic [35:0] cqx;
        logic [35:0] cqy;
        logic [30:0] cqr;
    } c_t;

    typedef struct packed {
        logic        line;
        logic        xneg;
        logic        yneg;
        logic        ov;
        logic [35:0] cqx;
        logic [35:0] cqy;
        logic [30:0] cqr;
    } side2_t;

    typedef struct packed {
        logic        line;
        logic        ov;
        logic [33:0] x0;
        logic [33:0] y0;
        logic [32:0] stx;
        logic [32:0] sty;
        logic [36:0] ex;
        logic [36:0] ey;
        logic [30:0] cqr;
    } e_t;

    typedef struct packed {
        logic        is_line;
        logic        overflow;
        logic [31:0] image_x;
        logic [31:0] image_y;
        logic [30:0] image_r;
        logic [31:0] seg_start_x;
        logic [31:0] seg_start_y;
        logic [31:0] seg_end_x;
        logic [31:0] seg_end_y;
    } out_t;

    logic        en;
    logic [61:0] rr2_reg;
    qword_t      b0_reg, b0_next;
    b1_t         b1_reg, b1_next;
    b2_t         b2_reg, b2_next;
    side1_t      sd1_reg [DIV_LAT];
    c_t          c_reg, c_next;
    side2_t      sd2_reg [DIV_LAT];
    e_t          e_reg, e_next;
    out_t        out_reg, out_next;
    logic        vb0_reg, vb1_reg, vb2_reg, vc_reg, ve_reg, vo_reg;
    logic        vd1_reg [DIV_LAT];
    logic        vd2_reg [DIV_LAT];

    logic [NUM_W-1:0] n1x;
    logic [DEN_W-1:0] d1x;
    logic [QUO_W-1:0] q1x, q1y, q1r, q2ox, q2oy, q2tx, q2ty;
    logic             o1x, o1y, o1r;
    side1_t           s1;
    side2_t           s2;

    // Returns {saturated, value} for a sum that may leave the 32 bit signed range.
    function automatic logic [32:0] sat32(input logic [36:0] v);
        logic [32:0] res;
        if (v[36:31] == 6'b000000 || v[36:31] == 6'b111111)
        begin
            res = {1'b0, v[31:0]};
        end
        else if (v[36])
        begin
            res = {1'b1, 32'h8000_0000};
        end
        else
        begin
            res = {1'b1, 32'h7FFF_FFFF};
        end
        return res;
    endfunction

    assign en  = !vo_reg || image.ready;
    assign pop = en && !empty;
    assign s1  = sd1_reg[DIV_LAT-1];
    assign s2  = sd2_reg[DIV_LAT-1];

    // The first divider also serves the line distance R*R / (2r).
    assign n1x = b2_reg.line ? NUM_W'(rr2_reg) : b2_reg.nx;
    assign d1x = b2_reg.line ? DEN_W'({b2_reg.r, 1'b0}) : b2_reg.den;

    ci_div u_div_x (.clk(clk), .en(en), .num(n1x), .den(d1x), .quo(q1x), .ovf(o1x));
    ci_div u_div_y (.clk(clk), .en(en), .num(b2_reg.ny), .den(b2_reg.den), .quo(q1y),
                    .ovf(o1y));
    ci_div u_div_r (.clk(clk), .en(en), .num(b2_reg.nr), .den(b2_reg.den), .quo(q1r),
                    .ovf(o1r));

    ci_div u_div_ox (.clk(clk), .en(en), .num(NUM_W'(c_reg.pox)), .den(DEN_W'(c_reg.dd)),
                     .quo(q2ox), .ovf());
    ci_div u_div_oy (.clk(clk), .en(en), .num(NUM_W'(c_reg.poy)), .den(DEN_W'(c_reg.dd)),
                     .quo(q2oy), .ovf());
    ci_div u_div_tx (.clk(clk), .en(en), .num(NUM_W'(c_reg.ptx)), .den(DEN_W'(c_reg.dd)),
                     .quo(q2tx), .ovf());
    ci_div u_div_ty (.clk(clk), .en(en), .num(NUM_W'(c_reg.pty)), .den(DEN_W'(c_reg.dd)),
                     .quo(q2ty), .ovf());

    always_comb
    begin
        // A line through a circle sitting on the centre uses the normal (1,0).
        b0_next = pop_word;
        if (pop_word.is_line && pop_word.dd == '0)
        begin
            b0_next.adx  = 33'd1;
            b0_next.ady  = '0;
            b0_next.dd   = 35'd1;
            b0_next.xneg = 1'b0;
            b0_next.yneg = 1'b0;
        end

        b1_next.w   = b0_reg;
        b1_next.r2  = 62'(b0_reg.r) * 62'(b0_reg.r);
        b1_next.pxl = 64'(rr2_reg[30:0]) * 64'(b0_reg.adx);
        b1_next.pxh = 64'(rr2_reg[61:31]) * 64'(b0_reg.adx);
        b1_next.pyl = 64'(rr2_reg[30:0]) * 64'(b0_reg.ady);
        b1_next.pyh = 64'(rr2_reg[61:31]) * 64'(b0_reg.ady);
        b1_next.prl = 62'(rr2_reg[30:0]) * 62'(b0_reg.r);
        b1_next.prh = 62'(rr2_reg[61:31]) * 62'(b0_reg.r);
    end

    always_comb
    begin
        b2_next.line = b1_reg.w.is_line;
        b2_next.xneg = b1_reg.w.xneg;
        b2_next.yneg = b1_reg.w.yneg;
        b2_next.adx  = b1_reg.w.adx;
        b2_next.ady  = b1_reg.w.ady;
        b2_next.dd   = b1_reg.w.dd;
        b2_next.r    = b1_reg.w.r;
        b2_next.nx   = NUM_W'({b1_reg.pxh, 31'b0}) + NUM_W'(b1_reg.pxl);
        b2_next.ny   = NUM_W'({b1_reg.pyh, 31'b0}) + NUM_W'(b1_reg.pyl);
        b2_next.nr   = NUM_W'({b1_reg.prh, 31'b0}) + NUM_W'(b1_reg.prl);
        b2_next.dneg = b1_reg.w.d2 < DEN_W'(b1_reg.r2);
        b2_next.den  = b2_next.dneg ? DEN_W'(b1_reg.r2) - b1_reg.w.d2
                                    : b1_reg.w.d2 - DEN_W'(b1_reg.r2);
    end

    always_comb
    begin
        logic        ovl, ovx, ovy, ovr;
        logic [30:0] line_dist;
        logic [34:0] qx, qy;
        ovl       = o1x || (q1x > 35'(MAX31));
        line_dist = ovl ? MAX31 : q1x[30:0];
        ovx       = o1x || (q1x > QCLAMP);
        ovy       = o1y || (q1y > QCLAMP);
        ovr       = o1r || (q1r > 35'(MAX31));
        qx        = ovx ? QCLAMP : q1x;
        qy        = ovy ? QCLAMP : q1y;

        c_next.line = s1.line;
        c_next.xneg = s1.xneg;
        c_next.yneg = s1.yneg;
        c_next.ov   = s1.line ? ovl : (ovx | ovy | ovr);
        c_next.dd   = s1.dd;
        c_next.pox  = 64'(s1.adx) * 64'(line_dist);
        c_next.poy  = 64'(s1.ady) * 64'(line_dist);
        c_next.ptx  = 64'(s1.adx) * 64'(cfg.span);
        c_next.pty  = 64'(s1.ady) * 64'(cfg.span);
        // When the centre lies inside the input circle, the image centre flips to the other side.
        c_next.cqx  = (s1.xneg ^ s1.dneg) ? 36'(0) - 36'(qx) : 36'(qx);
        c_next.cqy  = (s1.yneg ^ s1.dneg) ? 36'(0) - 36'(qy) : 36'(qy);
        c_next.cqr  = ovr ? MAX31 : q1r[30:0];
    end

    always_comb
    begin
        logic [32:0] sox, soy;
        sox = s2.xneg ? 33'(0) - 33'(q2ox) : 33'(q2ox);
        soy = s2.yneg ? 33'(0) - 33'(q2oy) : 33'(q2oy);
        e_next.line = s2.line;
        e_next.ov   = s2.ov;
        e_next.x0   = {{2{cfg.cx[31]}}, cfg.cx} + {sox[32], sox};
        e_next.y0   = {{2{cfg.cy[31]}}, cfg.cy} + {soy[32], soy};
        e_next.stx  = s2.xneg ? 33'(0) - 33'(q2tx) : 33'(q2tx);
        e_next.sty  = s2.yneg ? 33'(0) - 33'(q2ty) : 33'(q2ty);
        e_next.ex   = {{5{cfg.cx[31]}}, cfg.cx} + {s2.cqx[35], s2.cqx};
        e_next.ey   = {{5{cfg.cy[31]}}, cfg.cy} + {s2.cqy[35], s2.cqy};
        e_next.cqr  = s2.cqr;
    end

    always_comb
    begin
        logic [36:0] x0w, y0w, stxw, styw;
        logic [32:0] sa, sb, sc, sd, sx, sy;
        x0w  = {{3{e_reg.x0[33]}}, e_reg.x0};
        y0w  = {{3{e_reg.y0[33]}}, e_reg.y0};
        stxw = {{4{e_reg.stx[32]}}, e_reg.stx};
        styw = {{4{e_reg.sty[32]}}, e_reg.sty};
        sa   = sat32(x0w + styw);
        sb   = sat32(y0w - stxw);
        sc   = sat32(x0w - styw);
        sd   = sat32(y0w + stxw);
        sx   = sat32(e_reg.ex);
        sy   = sat32(e_reg.ey);
        out_next = '0;
        out_next.is_line = e_reg.line;
        if (e_reg.line)
        begin
            out_next.overflow    = e_reg.ov | sa[32] | sb[32] | sc[32] | sd[32];
            out_next.seg_start_x = sa[31:0];
            out_next.seg_start_y = sb[31:0];
            out_next.seg_end_x   = sc[31:0];
            out_next.seg_end_y   = sd[31:0];
        end
        else
        begin
            out_next.overflow = e_reg.ov | sx[32] | sy[32];
            out_next.image_x  = sx[31:0];
            out_next.image_y  = sy[31:0];
            out_next.image_r  = e_reg.cqr;
        end
    end

    always_ff @(posedge clk)
    begin
        rr2_reg <= 62'(cfg.radius) * 62'(cfg.radius);
        if (en)
        begin
            b0_reg     <= b0_next;
            b1_reg     <= b1_next;
            b2_reg     <= b2_next;
            sd1_reg[0] <= '{line: b2_reg.line, xneg: b2_reg.xneg, yneg: b2_reg.yneg,
                            dneg: b2_reg.dneg, adx: b2_reg.adx, ady: b2_reg.ady,
                            dd: b2_reg.dd};
            for (int i = 1; i < DIV_LAT; i++)
            begin
                sd1_reg[i] <= sd1_reg[i-1];
            end
            c_reg      <= c_next;
            sd2_reg[0] <= '{line: c_reg.line, xneg: c_reg.xneg, yneg: c_reg.yneg,
                            ov: c_reg.ov, cqx: c_reg.cqx, cqy: c_reg.cqy,
                            cqr: c_reg.cqr};
            for (int i = 1; i < DIV_LAT; i++)
            begin
                sd2_reg[i] <= sd2_reg[i-1];
            end
            e_reg      <= e_next;
            out_reg    <= out_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vb0_reg <= 1'b0;
            vb1_reg <= 1'b0;
            vb2_reg <= 1'b0;
            vc_reg  <= 1'b0;
            ve_reg  <= 1'b0;
            vo_reg  <= 1'b0;
            for (int i = 0; i < DIV_LAT; i++)
            begin
                vd1_reg[i] <= 1'b0;
                vd2_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            vb0_reg    <= !empty;
            vb1_reg    <= vb0_reg;
            vb2_reg    <= vb1_reg;
            vd1_reg[0] <= vb2_reg;
            vd2_reg[0] <= vc_reg;
            for (int i = 1; i < DIV_LAT; i++)
            begin
                vd1_reg[i] <= vd1_reg[i-1];
                vd2_reg[i] <= vd2_reg[i-1];
            end
            vc_reg     <= vd1_reg[DIV_LAT-1];
            ve_reg     <= vd2_reg[DIV_LAT-1];
            vo_reg     <= ve_reg;
        end
    end

    assign image.valid       = vo_reg;
    assign image.is_line     = out_reg.is_line;
    assign image.overflow    = out_reg.overflow;
    assign image.image_x     = out_reg.image_x;
    assign image.image_y     = out_reg.image_y;
    assign image.image_r     = out_reg.image_r;
    assign image.seg_start_x = out_reg.seg_start_x;
    assign image.seg_start_y = out_reg.seg_start_y;
    assign image.seg_end_x   = out_reg.seg_end_x;
    assign image.seg_end_y   = out_reg.seg_end_y;

endmodule

FILE: hdl/circle_inversion.sv
`timescale 1ns / 1ps
// Throughput: one circle per cycle while the front is not held by a full queue;
// the square root and the two divider chains are fully pipelined, one root or
// quotient bit per stage.
// A four-word queue separates the front from the back, so each side stalls on its own.
// Reset clears all valid bits and the queue and loads the registers' reset values.
module circle_inversion import ci_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    ci_in_if.sink             circle,
    ci_out_if.source          image
);

    logic [31:0] cx_reg, cy_reg;
    logic [30:0] radius_reg, span_reg;
    logic [15:0] tol_reg;
    cfg_t        cfg;
    logic        wr_en;
    logic        q_push, q_full, q_pop, q_empty;
    qword_t      q_in, q_out;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg     <= '0;
            cy_reg     <= '0;
            radius_reg <= RADIUS_RST;
            span_reg   <= SPAN_RST;
            tol_reg    <= '0;
        end
        else if (wr_en)
        begin
            case (paddr[4:2])
                REG_CX:     cx_reg     <= pwdata;
                REG_CY:     cy_reg     <= pwdata;
                REG_RADIUS: radius_reg <= pwdata[30:0];
                REG_SPAN:   span_reg   <= pwdata[30:0];
                REG_TOL:    tol_reg    <= pwdata[15:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            REG_CX:     prdata = cx_reg;
            REG_CY:     prdata = cy_reg;
            REG_RADIUS: prdata = 32'(radius_reg);
            REG_SPAN:   prdata = 32'(span_reg);
            REG_TOL:    prdata = 32'(tol_reg);
            default:    prdata = '0;
        endcase
    end

    assign cfg.cx     = cx_reg;
    assign cfg.cy     = cy_reg;
    assign cfg.radius = radius_reg;
    assign cfg.span   = span_reg;
    assign cfg.tol    = tol_reg;

    ci_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .circle    (circle),
        .push      (q_push),
        .push_word (q_in),
        .full      (q_full)
    );

    ci_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_word (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_word  (q_out),
        .empty     (q_empty)
    );

    ci_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .pop      (q_pop),
        .pop_word (q_out),
        .empty    (q_empty),
        .image    (image)
    );

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_push && q_full))
        else $error("classified word pushed into a full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_pop && q_empty))
        else $error("word popped from an empty queue");

    a_line_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (image.valid && image.is_line) |->
        (image.image_x == '0 && image.image_y == '0 && image.image_r == '0))
        else $error("line result carries circle fields");

    a_circle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (image.valid && !image.is_line) |->
        (image.seg_start_x == '0 && image.seg_start_y == '0 &&
         image.seg_end_x == '0 && image.seg_end_y == '0))
        else $error("circle result carries segment fields");

endmodule
